>>> rtl/tks_pkg.sv
`default_nettype none

package tks_pkg;

  localparam int VAR_FRAC = 30;
  localparam int DIG_STEPS = VAR_FRAC + 1;
  localparam logic [30:0] VAR_ONE = 31'(1) << VAR_FRAC;

  localparam logic [31:0] PROCESS_NOISE_RESET = 32'd4294967;
  localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'd268435456;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } shift_item_t;

  typedef struct packed {
    logic signed [31:0] corrected_x;
    logic signed [31:0] corrected_y;
    logic signed [47:0] smoothed_x;
    logic signed [47:0] smoothed_y;
  } smooth_item_t;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if ((v[49:31] != '0) && (v[49:31] != '1)) begin
      r = v[49] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/trajectory_kalman_smoother.sv
// Trajectory smoother: running sum of frame shifts, scalar Kalman filter per axis.
// One frame at a time: the input stalls until the previous frame's result is in
// the output register. Each later frame runs the 31-step bit-serial gain
// divider followed by the 31-step serial multipliers; the first frame skips them.
// Reset (rst, synchronous): trajectory and estimates zero, variance 1.0,
// noise registers to their defaults, no frame seen, output empty.
`default_nettype none

module trajectory_kalman_smoother import tks_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // frame shifts in
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire shift_item_t  in_item,
  // smoothed results out
  output logic              out_valid,
  input  wire logic         out_stall,
  output smooth_item_t      out_item,
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire reg_index_t   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  // Sequencer, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PATH  = 10'b0000000010,  // trajectory update
    S_PRIOR = 10'b0000000100,  // prior = sat(P + q)
    S_DEN   = 10'b0000001000,  // denominator, divider load, innovation
    S_DIV   = 10'b0000010000,  // restoring divide, one quotient bit a cycle
    S_PREP  = 10'b0000100000,  // gain clamp, magnitudes, multiplier load
    S_MUL   = 10'b0001000000,  // shift-add multiply, one gain bit a cycle
    S_UPD   = 10'b0010000000,  // estimate and variance write-back
    S_CORR1 = 10'b0100000000,  // estimate - path
    S_CORR2 = 10'b1000000000   // + shift, saturate, into output register
  } state_t;

  state_t state;
  logic [4:0] cnt;

  // configuration and filter state
  logic [31:0] process_noise;
  logic [31:0] measurement_noise;
  logic signed [47:0] path_x, path_y;
  logic signed [47:0] estimate_x, estimate_y;
  logic [31:0] error_variance;
  logic started;

  // working registers
  logic signed [31:0] sx, sy;
  logic [31:0] prior;
  logic [32:0] denom;
  logic [32:0] rem;
  logic [30:0] num;       // dividend low bits in, quotient bits out
  logic signed [48:0] diff_x, diff_y;
  logic [30:0] gsh;       // gain, consumed LSB first
  logic [30:0] ish;       // 1 - gain, consumed LSB first
  logic [47:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic [48:0] acc_x, acc_y;
  logic [32:0] acc_p;
  logic signed [48:0] cd_x, cd_y;

  logic last_step;
  assign last_step = (cnt == 5'(DIG_STEPS - 1));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  logic in_acc, out_take;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = !out_valid || !out_stall;

  // ---- combinational datapath pieces ----
  logic signed [47:0] path_x_sum, path_y_sum;
  logic [32:0] prior_sum;
  logic [33:0] div_trial;
  logic div_ge;
  logic [30:0] gain;
  logic [49:0] mx_sum, my_sum;
  logic [33:0] mp_sum;
  logic signed [48:0] upd_x, upd_y;

  always_comb begin
    path_x_sum = sat48(49'(sx) + 49'(path_x));
    path_y_sum = sat48(49'(sy) + 49'(path_y));
    prior_sum  = {1'b0, error_variance} + {1'b0, process_noise};
    div_trial  = {rem, num[30]};
    div_ge     = (div_trial >= {1'b0, denom});
    if (denom == '0) begin
      gain = VAR_ONE;
    end else if (num > VAR_ONE) begin
      gain = VAR_ONE;
    end else begin
      gain = num;
    end
    mx_sum = {1'b0, acc_x} + (gsh[0] ? {2'b0, mag_x} : 50'd0);
    my_sum = {1'b0, acc_y} + (gsh[0] ? {2'b0, mag_y} : 50'd0);
    mp_sum = {1'b0, acc_p} + (ish[0] ? {2'b0, prior} : 34'd0);
    upd_x  = neg_x ? (49'(estimate_x) - $signed(acc_x)) : (49'(estimate_x) + $signed(acc_x));
    upd_y  = neg_y ? (49'(estimate_y) - $signed(acc_y)) : (49'(estimate_y) + $signed(acc_y));
  end

  // ---- control and filter state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cnt               <= '0;
      out_valid         <= 1'b0;
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
      path_x            <= '0;
      path_y            <= '0;
      estimate_x        <= '0;
      estimate_y        <= '0;
      error_variance    <= {2'b01, 30'd0};
      started           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     process_noise     <= cfg_data;
          REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
          default: ;
        endcase
      end

      // result taken; in S_CORR2 the output register is refilled below instead
      if (out_valid && !out_stall && (state != S_CORR2)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_PATH;
          end
        end
        S_PATH: begin
          path_x <= path_x_sum;
          path_y <= path_y_sum;
          if (!started) begin
            // first frame: filter starts from zero estimate, unit variance
            estimate_x     <= '0;
            estimate_y     <= '0;
            error_variance <= {2'b01, 30'd0};
            started        <= 1'b1;
            state          <= S_CORR1;
          end else begin
            state <= S_PRIOR;
          end
        end
        S_PRIOR: state <= S_DEN;
        S_DEN: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (last_step) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 5'd1;
          if (last_step) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          estimate_x     <= sat48(upd_x);
          estimate_y     <= sat48(upd_y);
          error_variance <= acc_p[31:0];
          state          <= S_CORR1;
        end
        S_CORR1: state <= S_CORR2;
        S_CORR2: begin
          // hold here while the previous result has not been taken
          if (out_take) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- working datapath, no reset needed ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          sx <= in_item.shift_x;
          sy <= in_item.shift_y;
        end
      end
      S_PRIOR: begin
        prior <= prior_sum[32] ? '1 : prior_sum[31:0];
      end
      S_DEN: begin
        // dividend is prior << 30; top bits preloaded so 31 steps give the quotient
        denom  <= {1'b0, prior} + {1'b0, measurement_noise};
        rem    <= {2'b0, prior[31:1]};
        num    <= {prior[0], 30'd0};
        diff_x <= 49'(path_x) - 49'(estimate_x);
        diff_y <= 49'(path_y) - 49'(estimate_y);
      end
      S_DIV: begin
        rem <= div_ge ? 33'(div_trial - {1'b0, denom}) : div_trial[32:0];
        num <= {num[29:0], div_ge};
      end
      S_PREP: begin
        gsh   <= gain;
        ish   <= VAR_ONE - gain;
        neg_x <= diff_x[48];
        neg_y <= diff_y[48];
        mag_x <= diff_x[48] ? 48'(-diff_x) : diff_x[47:0];
        mag_y <= diff_y[48] ? 48'(-diff_y) : diff_y[47:0];
        acc_x <= '0;
        acc_y <= '0;
        acc_p <= '0;
      end
      S_MUL: begin
        // right-shifting product: dropped bits are the truncated fraction
        gsh <= gsh >> 1;
        ish <= ish >> 1;
        if (last_step) begin
          acc_x <= mx_sum[48:0];
          acc_y <= my_sum[48:0];
          acc_p <= mp_sum[32:0];
        end else begin
          acc_x <= mx_sum[49:1];
          acc_y <= my_sum[49:1];
          acc_p <= mp_sum[33:1];
        end
      end
      S_CORR1: begin
        cd_x <= 49'(estimate_x) - 49'(path_x);
        cd_y <= 49'(estimate_y) - 49'(path_y);
      end
      S_CORR2: begin
        if (out_take) begin
          out_item.corrected_x <= sat32(50'(sx) + 50'(cd_x));
          out_item.corrected_y <= sat32(50'(sy) + 50'(cd_y));
          out_item.smoothed_x  <= estimate_x;
          out_item.smoothed_y  <= estimate_y;
        end
      end
      default: ;
    endcase
  end

  // ---- checks ----
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_PATH)
    else $error("accepted item did not start the sequence");

  a_gain_split: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL && cnt == '0 |-> ({1'b0, gsh} + {1'b0, ish}) == {1'b0, VAR_ONE})
    else $error("gain and its complement do not sum to one");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> acc_x <= {1'b0, mag_x} && acc_y <= {1'b0, mag_y})
    else $error("estimate step exceeds innovation");

  a_var_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> acc_p <= {1'b0, prior})
    else $error("posterior variance exceeds prior");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench import tks_pkg::*; ();

  localparam int HOLD_CYCLES = 3000;       // long receiver hold-off, once
  localparam int HOLD_AFTER = 300;         // items taken before the hold-off starts
  localparam int PHASE_ITEMS = 155;        // random items per noise setting
  localparam int NOISE_PHASES = 8;
  localparam int TAIL_CYCLES = 100;        // idle time before the final verdict
  localparam int unsigned LIMIT = 2000000;

  // Own model of the smoother: trajectory, per-axis estimate, shared variance.
  // Keeps the queue of smoothed items still owed by the block.
  class smooth_tracker;
    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -MAX48 - 1;
    localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam longint MIN32 = -MAX32 - 1;
    localparam longint unsigned GAIN_ONE = 64'd1 << VAR_FRAC;
    localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

    logic [31:0] q_noise;
    logic [31:0] r_noise;
    longint path_x;
    longint path_y;
    longint est_x;
    longint est_y;
    longint unsigned variance;
    bit started;
    smooth_item_t expected_smooth[$];
    int errors;
    int results_seen;

    function new();
      q_noise = PROCESS_NOISE_RESET;
      r_noise = MEASUREMENT_NOISE_RESET;
      path_x = 0;
      path_y = 0;
      est_x = 0;
      est_y = 0;
      variance = GAIN_ONE;
      started = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_noise(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_PROCESS_NOISE: begin
          q_noise = value;
        end
        REG_MEASUREMENT_NOISE: begin
          r_noise = value;
        end
        default: begin
        end
      endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // step toward target by gain, magnitude truncated so it rounds toward zero
    static function longint blend(longint old_v, longint target, longint unsigned gain);
      longint diff;
      longint stp;
      longint unsigned mag;
      diff = target - old_v;
      mag = (diff < 0) ? -diff : diff;
      stp = longint'((mag >> VAR_FRAC) * gain + (((mag & (GAIN_ONE - 1)) * gain) >> VAR_FRAC));
      return clamp((diff < 0) ? old_v - stp : old_v + stp, MIN48, MAX48);
    endfunction

    function void note_shift(shift_item_t item);
      longint sx;
      longint sy;
      longint unsigned prior;
      longint unsigned denom;
      longint unsigned gain;
      smooth_item_t want;
      sx = $signed(item.shift_x);
      sy = $signed(item.shift_y);
      path_x = clamp(path_x + sx, MIN48, MAX48);
      path_y = clamp(path_y + sy, MIN48, MAX48);
      if (!started) begin
        est_x = 0;
        est_y = 0;
        variance = GAIN_ONE;
        started = 1'b1;
      end else begin
        prior = variance + q_noise;
        if (prior > MASK32) prior = MASK32;
        denom = prior + r_noise;
        gain = (denom == 0) ? GAIN_ONE : (prior << VAR_FRAC) / denom;
        if (gain > GAIN_ONE) gain = GAIN_ONE;
        est_x = blend(est_x, path_x, gain);
        est_y = blend(est_y, path_y, gain);
        variance = (((GAIN_ONE - gain) * prior) >> VAR_FRAC) & MASK32;
      end
      want.corrected_x = 32'(clamp(sx + est_x - path_x, MIN32, MAX32));
      want.corrected_y = 32'(clamp(sy + est_y - path_y, MIN32, MAX32));
      want.smoothed_x = 48'(est_x);
      want.smoothed_y = 48'(est_y);
      expected_smooth = {expected_smooth, want};
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t: item %0d: %s", $time, results_seen, what);
    endtask

    task check_smooth(smooth_item_t got);
      smooth_item_t want;
      if (expected_smooth.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", got));
      end else begin
        want = expected_smooth.pop_front();
        if (got.corrected_x !== want.corrected_x)
          report($sformatf("corrected_x %h, want %h", got.corrected_x, want.corrected_x));
        if (got.corrected_y !== want.corrected_y)
          report($sformatf("corrected_y %h, want %h", got.corrected_y, want.corrected_y));
        if (got.smoothed_x !== want.smoothed_x)
          report($sformatf("smoothed_x %h, want %h", got.smoothed_x, want.smoothed_x));
        if (got.smoothed_y !== want.smoothed_y)
          report($sformatf("smoothed_y %h, want %h", got.smoothed_y, want.smoothed_y));
      end
      results_seen++;
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  shift_item_t  in_item;
  logic         out_valid;
  logic         out_stall;
  smooth_item_t out_item;
  logic         cfg_valid;
  logic         cfg_ready;
  reg_index_t   cfg_index;
  logic [31:0]  cfg_data;

  smooth_tracker kalman;
  int shifts_taken = 0;
  int burst_left = 0;

  trajectory_kalman_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one item, hold it until taken. Items go out in bursts; when a burst
  // runs out, valid drops for a random gap (sometimes none) before the next.
  task automatic offer_shift(input shift_item_t item);
    int gap;
    in_item <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and let every owed result come out: the block is then idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (kalman.expected_smooth.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_noise(input reg_index_t idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly full-range words (every bit toggles) or camera-sized pans within
  // +/-1048576, with the odd extreme thrown in.
  function automatic logic [31:0] pick_shift();
    int pan;
    pan = $urandom_range(0, 2097152);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return 32'(pan - 1048576);
      8: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0001;
    endcase
  endfunction

  // Noise values: either anywhere in the 32-bit word or in the sane 0..1.0 band.
  function automatic logic [31:0] pick_noise();
    if ($urandom_range(0, 1) != 0) return $urandom;
    return $urandom_range(0, 1 << 30);
  endfunction

  // Opening frames at reset noise values. The first frame carries the field
  // extremes; a run of full positive pans then full negative pans lets the
  // estimate lag the trajectory far enough to clip the corrected output both ways.
  function automatic shift_item_t directed_shift(int n);
    shift_item_t s;
    case (n)
      0: s = {32'h7FFF_FFFF, 32'h8000_0000};
      1: s = {32'h0000_0000, 32'h0000_0000};
      2: s = {32'h8000_0000, 32'h7FFF_FFFF};
      3: s = {32'hFFFF_FFFF, 32'h0000_0001};
      4: s = {32'h0001_0000, 32'hFFFF_0000};
      5, 6, 7, 8, 9: s = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
      default: s = {32'h8000_0000, 32'h8000_0000};
    endcase
    return s;
  endfunction

  // Receiver: stall pattern changes per stretch - free running, light, heavy,
  // or solid for a short while. Once, a long hold-off lets the block back up
  // and push stall onto the sender.
  initial begin : receiver
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(10, 300);
      repeat (span) begin
        @(posedge clk);
        if (!held && shifts_taken >= HOLD_AFTER) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Handshake monitor: register writes and taken items update the model,
  // delivered items are checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) kalman.set_noise(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        kalman.note_shift(in_item);
        shifts_taken <= shifts_taken + 1;
      end
      if (out_valid && !out_stall) kalman.check_smooth(out_item);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] q_set;
    logic [31:0] r_set;
    kalman = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < 20; n++) offer_shift(directed_shift(n));
    settle();

    // Noise settings: gain pinned to 1 with zero denominator, saturating prior,
    // widest denominator, tiny gain, a few random ones, then back to reset values.
    for (int p = 0; p < NOISE_PHASES; p++) begin
      case (p)
        0: begin q_set = 32'h0000_0000; r_set = 32'h0000_0000; end
        1: begin q_set = 32'hFFFF_FFFF; r_set = 32'h0000_0000; end
        2: begin q_set = 32'hFFFF_FFFF; r_set = 32'hFFFF_FFFF; end
        3: begin q_set = 32'h0000_0000; r_set = 32'hFFFF_FFFF; end
        7: begin q_set = PROCESS_NOISE_RESET; r_set = MEASUREMENT_NOISE_RESET; end
        default: begin q_set = pick_noise(); r_set = pick_noise(); end
      endcase
      write_noise(REG_PROCESS_NOISE, q_set);
      write_noise(REG_MEASUREMENT_NOISE, r_set);
      for (int n = 0; n < PHASE_ITEMS; n++) offer_shift({pick_shift(), pick_shift()});
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (kalman.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
